>>> rtl/core/sltok_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sltok_pkg
// Shared types and constants of the stack language token scanner: result
// kinds, character codes, run classes, field limits and the result record.
// ----------------------------------------------------------------------------
package sltok_pkg;

    // result field widths
    localparam int KIND_BITS       = 4;
    localparam int CHAR_BITS       = 8;
    localparam int FIELD_LINE_BITS = 20;
    localparam int FIELD_COL_BITS  = 16;
    localparam int FIELD_LEN_BITS  = 16;

    localparam logic [FIELD_LINE_BITS-1:0] FIELD_LINE_MAX = '1;
    localparam logic [FIELD_COL_BITS-1:0]  FIELD_COL_MAX  = '1;
    localparam logic [FIELD_LEN_BITS-1:0]  FIELD_LEN_MAX  = '1;

    // default counter widths
    localparam int LINE_BITS_DEF   = 20;
    localparam int COLUMN_BITS_DEF = 16;

    // result queue
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int PUSH_MAX        = 3;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_NAME        = 4'd0,
        KIND_NUMBER      = 4'd1,
        KIND_MOVE        = 4'd2,
        KIND_COPY        = 4'd3,
        KIND_ZERO_OPEN   = 4'd4,
        KIND_ZERO_CLOSE  = 4'd5,
        KIND_EMPTY_OPEN  = 4'd6,
        KIND_EMPTY_CLOSE = 4'd7,
        KIND_BAD_CHAR    = 4'd8,
        KIND_END         = 4'd9
    } t_kind;

    typedef enum logic [1:0] {
        RUN_NONE   = 2'd0,
        RUN_LETTER = 2'd1,
        RUN_DIGIT  = 2'd2
    } t_run_class;

    // character codes
    localparam logic [CHAR_BITS-1:0] CH_GT      = 8'h3E;
    localparam logic [CHAR_BITS-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_LBRACK  = 8'h5B;
    localparam logic [CHAR_BITS-1:0] CH_RBRACK  = 8'h5D;
    localparam logic [CHAR_BITS-1:0] CH_LBRACE  = 8'h7B;
    localparam logic [CHAR_BITS-1:0] CH_RBRACE  = 8'h7D;
    localparam logic [CHAR_BITS-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_BITS-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_LOW_A   = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LOW_Z   = 8'h7A;
    localparam logic [CHAR_BITS-1:0] CH_UP_A    = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UP_Z    = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE    = 8'h39;

    typedef struct packed {
        t_kind                      kind;
        logic [FIELD_LINE_BITS-1:0] start_line;
        logic [FIELD_COL_BITS-1:0]  start_column;
        logic [FIELD_LEN_BITS-1:0]  token_length;
        logic [CHAR_BITS-1:0]       bad_byte;
        logic                       had_error;
        logic                       last_result;
    } t_result;

endpackage

>>> rtl/core/sltok_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sltok_in_if / sltok_out_if
// Valid/ready channels of the token scanner: source bytes in, token
// results out.
// ----------------------------------------------------------------------------
interface sltok_in_if;
    logic                            valid;
    logic                            ready;
    logic [sltok_pkg::CHAR_BITS-1:0] char_byte;
    logic                            end_of_code;

    modport source (output valid, output char_byte, output end_of_code, input ready);
    modport sink   (input valid, input char_byte, input end_of_code, output ready);
endinterface

interface sltok_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [sltok_pkg::KIND_BITS-1:0]       kind;
    logic [sltok_pkg::FIELD_LINE_BITS-1:0] start_line;
    logic [sltok_pkg::FIELD_COL_BITS-1:0]  start_column;
    logic [sltok_pkg::FIELD_LEN_BITS-1:0]  token_length;
    logic [sltok_pkg::CHAR_BITS-1:0]       bad_byte;
    logic                                  had_error;
    logic                                  last_result;

    modport source (
        output valid, output kind, output start_line, output start_column,
        output token_length, output bad_byte, output had_error, output last_result,
        input ready
    );
    modport sink (
        input valid, input kind, input start_line, input start_column,
        input token_length, input bad_byte, input had_error, input last_result,
        output ready
    );
endinterface

>>> rtl/core/sltok_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sltok_queue
// Result queue: takes up to PUSH results per cycle, in order, and hands
// them out one transfer at a time; DEPTH must be a power of two, unchecked.
// ----------------------------------------------------------------------------
module sltok_queue #(
    parameter int DEPTH = sltok_pkg::QUEUE_DEPTH_DEF,
    parameter int PUSH  = sltok_pkg::PUSH_MAX
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [PUSH-1:0]          i_push_valid,
    input  sltok_pkg::t_result       i_push_item [PUSH],
    output logic                     o_room,
    sltok_out_if.source              o_out
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    sltok_pkg::t_result  r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;

    logic [PTR_BITS-1:0] w_waddr [PUSH];
    logic [CNT_BITS-1:0] w_push_n;
    logic                w_pop;
    sltok_pkg::t_result  w_head;

    always_comb begin
        logic [CNT_BITS-1:0] acc;
        acc = '0;
        for (int k = 0; k < PUSH; k++) begin
            w_waddr[k] = r_wr_ptr + PTR_BITS'(acc);
            acc = acc + CNT_BITS'(i_push_valid[k]);
        end
        w_push_n = acc;
    end

    assign w_pop  = o_out.valid && o_out.ready;
    assign o_room = (r_count <= CNT_BITS'(DEPTH - PUSH));
    assign w_head = r_mem[r_rd_ptr];

    assign o_out.valid        = (r_count != '0);
    assign o_out.kind         = w_head.kind;
    assign o_out.start_line   = w_head.start_line;
    assign o_out.start_column = w_head.start_column;
    assign o_out.token_length = w_head.token_length;
    assign o_out.bad_byte     = w_head.bad_byte;
    assign o_out.had_error    = w_head.had_error;
    assign o_out.last_result  = w_head.last_result;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < PUSH; k++) begin
            if (i_push_valid[k]) begin
                r_mem[w_waddr[k]] <= i_push_item[k];
            end
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_BITS'(w_push_n);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_BITS'(1);
            end
            r_count <= r_count + w_push_n - CNT_BITS'(w_pop);
        end
    end

    // pushes only land when there is room for a full group
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_n != '0) |-> (r_count <= CNT_BITS'(DEPTH - PUSH)))
        else $error("result queue pushed without room");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(DEPTH))
        else $error("result queue count beyond depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_rd_ptr == r_wr_ptr))
        else $error("empty queue with unequal pointers");

endmodule

>>> rtl/core/stack_language_token_scanner.sv
`timescale 1ns / 1ps
// each byte passes through the input register, then its results are written into the result queue
// throughput: one byte per cycle unless stalled; an input register feeds single-pass scan logic
// that writes up to three results per byte into an eight-entry result queue
// a byte waits in the input register while the queue holds more than five results
// reset: synchronous, active low; clears the open run, sets line and column to 1,
// clears the error flag and empties the queue; end of code restores the same scan state
// ----------------------------------------------------------------------------
// stack_language_token_scanner
// Character-class scanner: letter and digit runs become name and number
// tokens, six operator bytes become single tokens, and an end item closes
// each source with an error flag.
// ----------------------------------------------------------------------------
module stack_language_token_scanner #(
    parameter int LINE_BITS   = sltok_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = sltok_pkg::COLUMN_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sltok_in_if.sink    i_in,
    sltok_out_if.source o_out
);

    localparam int PUSH     = sltok_pkg::PUSH_MAX;
    localparam int LINE_EXT = (LINE_BITS > sltok_pkg::FIELD_LINE_BITS)
                              ? LINE_BITS : sltok_pkg::FIELD_LINE_BITS;
    localparam int COL_EXT  = (COLUMN_BITS > sltok_pkg::FIELD_COL_BITS)
                              ? COLUMN_BITS : sltok_pkg::FIELD_COL_BITS;

    // input register
    logic                            r_in_valid;
    logic [sltok_pkg::CHAR_BITS-1:0] r_char;
    logic                            r_eoc;

    // scan state
    sltok_pkg::t_run_class                 r_run_class, n_run_class;
    logic [sltok_pkg::FIELD_LINE_BITS-1:0] r_run_line, n_run_line;
    logic [sltok_pkg::FIELD_COL_BITS-1:0]  r_run_column, n_run_column;
    logic [sltok_pkg::FIELD_LEN_BITS-1:0]  r_run_length, n_run_length;
    logic [LINE_BITS-1:0]                  r_line_count, n_line_count;
    logic [COLUMN_BITS-1:0]                r_column_count, n_column_count;
    logic                                  r_error_seen, n_error_seen;

    logic                                  w_room;
    logic                                  w_process;
    logic                                  w_accept;
    sltok_pkg::t_run_class                 w_cls;
    logic                                  w_is_op;
    sltok_pkg::t_kind                      w_op_kind;
    logic [LINE_EXT-1:0]                   w_line_ext;
    logic [COL_EXT-1:0]                    w_col_ext;
    logic [sltok_pkg::FIELD_LINE_BITS-1:0] w_line_clip;
    logic [sltok_pkg::FIELD_COL_BITS-1:0]  w_col_clip;
    logic [PUSH-1:0]                       w_res_valid;
    sltok_pkg::t_result                    w_res [PUSH];

    assign w_process  = r_in_valid && w_room;
    assign i_in.ready = !r_in_valid || w_process;
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        if ((r_char >= sltok_pkg::CH_LOW_A && r_char <= sltok_pkg::CH_LOW_Z) ||
            (r_char >= sltok_pkg::CH_UP_A && r_char <= sltok_pkg::CH_UP_Z)) begin
            w_cls = sltok_pkg::RUN_LETTER;
        end else if (r_char >= sltok_pkg::CH_ZERO && r_char <= sltok_pkg::CH_NINE) begin
            w_cls = sltok_pkg::RUN_DIGIT;
        end else begin
            w_cls = sltok_pkg::RUN_NONE;
        end
    end

    always_comb begin
        w_is_op   = 1'b1;
        w_op_kind = sltok_pkg::KIND_MOVE;
        unique case (r_char)
            sltok_pkg::CH_GT:     w_op_kind = sltok_pkg::KIND_MOVE;
            sltok_pkg::CH_PLUS:   w_op_kind = sltok_pkg::KIND_COPY;
            sltok_pkg::CH_LBRACK: w_op_kind = sltok_pkg::KIND_ZERO_OPEN;
            sltok_pkg::CH_RBRACK: w_op_kind = sltok_pkg::KIND_ZERO_CLOSE;
            sltok_pkg::CH_LBRACE: w_op_kind = sltok_pkg::KIND_EMPTY_OPEN;
            sltok_pkg::CH_RBRACE: w_op_kind = sltok_pkg::KIND_EMPTY_CLOSE;
            default:              w_is_op   = 1'b0;
        endcase
    end

    // positions clipped to the result field widths
    assign w_line_ext  = LINE_EXT'(r_line_count);
    assign w_col_ext   = COL_EXT'(r_column_count);
    assign w_line_clip = (w_line_ext > LINE_EXT'(sltok_pkg::FIELD_LINE_MAX))
                         ? sltok_pkg::FIELD_LINE_MAX
                         : w_line_ext[sltok_pkg::FIELD_LINE_BITS-1:0];
    assign w_col_clip  = (w_col_ext > COL_EXT'(sltok_pkg::FIELD_COL_MAX))
                         ? sltok_pkg::FIELD_COL_MAX
                         : w_col_ext[sltok_pkg::FIELD_COL_BITS-1:0];

    always_comb begin
        n_run_class    = r_run_class;
        n_run_line     = r_run_line;
        n_run_column   = r_run_column;
        n_run_length   = r_run_length;
        n_line_count   = r_line_count;
        n_column_count = r_column_count;
        n_error_seen   = r_error_seen;
        w_res_valid    = '0;
        for (int k = 0; k < PUSH; k++) begin
            w_res[k] = '0;
        end

        if (w_process) begin
            // close a run of another class
            if (r_run_class != w_cls && r_run_class != sltok_pkg::RUN_NONE) begin
                w_res_valid[0]        = 1'b1;
                w_res[0].kind         = (r_run_class == sltok_pkg::RUN_LETTER)
                                        ? sltok_pkg::KIND_NAME : sltok_pkg::KIND_NUMBER;
                w_res[0].start_line   = r_run_line;
                w_res[0].start_column = r_run_column;
                w_res[0].token_length = r_run_length;
                n_run_class  = sltok_pkg::RUN_NONE;
                n_run_line   = '0;
                n_run_column = '0;
                n_run_length = '0;
            end

            if (w_cls != sltok_pkg::RUN_NONE) begin
                if (r_run_class == w_cls) begin
                    if (r_run_length != sltok_pkg::FIELD_LEN_MAX) begin
                        n_run_length = r_run_length + sltok_pkg::FIELD_LEN_BITS'(1);
                    end
                end else begin
                    n_run_class  = w_cls;
                    n_run_line   = w_line_clip;
                    n_run_column = w_col_clip;
                    n_run_length = sltok_pkg::FIELD_LEN_BITS'(1);
                end
                if (r_eoc) begin
                    w_res_valid[1]        = 1'b1;
                    w_res[1].kind         = (w_cls == sltok_pkg::RUN_LETTER)
                                            ? sltok_pkg::KIND_NAME : sltok_pkg::KIND_NUMBER;
                    w_res[1].start_line   = n_run_line;
                    w_res[1].start_column = n_run_column;
                    w_res[1].token_length = n_run_length;
                end
            end else if (w_is_op) begin
                w_res_valid[1]        = 1'b1;
                w_res[1].kind         = w_op_kind;
                w_res[1].start_line   = w_line_clip;
                w_res[1].start_column = w_col_clip;
                w_res[1].token_length = sltok_pkg::FIELD_LEN_BITS'(1);
            end else if (r_char == sltok_pkg::CH_NEWLINE) begin
                if (r_line_count != '1) begin
                    n_line_count = r_line_count + LINE_BITS'(1);
                end
            end else if (r_char != sltok_pkg::CH_SPACE && r_char != sltok_pkg::CH_TAB) begin
                w_res_valid[1]        = 1'b1;
                w_res[1].kind         = sltok_pkg::KIND_BAD_CHAR;
                w_res[1].start_line   = w_line_clip;
                w_res[1].start_column = w_col_clip;
                w_res[1].token_length = sltok_pkg::FIELD_LEN_BITS'(1);
                w_res[1].bad_byte     = r_char;
                n_error_seen          = 1'b1;
            end

            // newline restarts at column 1
            if (r_char == sltok_pkg::CH_NEWLINE) begin
                n_column_count = COLUMN_BITS'(1);
            end else if (r_column_count != '1) begin
                n_column_count = r_column_count + COLUMN_BITS'(1);
            end

            if (r_eoc) begin
                w_res_valid[2]     = 1'b1;
                w_res[2].kind      = sltok_pkg::KIND_END;
                w_res[2].had_error = n_error_seen;
                n_run_class    = sltok_pkg::RUN_NONE;
                n_run_line     = '0;
                n_run_column   = '0;
                n_run_length   = '0;
                n_line_count   = LINE_BITS'(1);
                n_column_count = COLUMN_BITS'(1);
                n_error_seen   = 1'b0;
            end

            w_res[0].last_result = w_res_valid[0] && !w_res_valid[1] && !w_res_valid[2];
            w_res[1].last_result = w_res_valid[1] && !w_res_valid[2];
            w_res[2].last_result = w_res_valid[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_char <= i_in.char_byte;
            r_eoc  <= i_in.end_of_code;
        end
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_run_class    <= sltok_pkg::RUN_NONE;
            r_run_line     <= '0;
            r_run_column   <= '0;
            r_run_length   <= '0;
            r_line_count   <= LINE_BITS'(1);
            r_column_count <= COLUMN_BITS'(1);
            r_error_seen   <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_process) begin
                r_in_valid <= 1'b0;
            end
            r_run_class    <= n_run_class;
            r_run_line     <= n_run_line;
            r_run_column   <= n_run_column;
            r_run_length   <= n_run_length;
            r_line_count   <= n_line_count;
            r_column_count <= n_column_count;
            r_error_seen   <= n_error_seen;
        end
    end

    sltok_queue #(
        .DEPTH (sltok_pkg::QUEUE_DEPTH_DEF),
        .PUSH  (PUSH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_res_valid),
        .i_push_item  (w_res),
        .o_room       (w_room),
        .o_out        (o_out)
    );

    // end of code returns the scan state to its reset values
    a_end_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_process && r_eoc) |=> (r_run_class == sltok_pkg::RUN_NONE &&
                                  r_error_seen == 1'b0 &&
                                  r_line_count == LINE_BITS'(1)))
        else $error("state not restored after end of code");

    a_run_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run_class == sltok_pkg::RUN_NONE) == (r_run_length == '0))
        else $error("run length disagrees with run class");

    a_column_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_column_count != '0)
        else $error("column counter at zero");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stack language token scanner. A queue of
// source bytes (directed cases, then random sources of well-formed tokens
// mixed with noise) feeds a valid/ready driver. Every byte transfer runs a
// local scanner model that queues the tokens it predicts; a monitor compares
// each result transfer with the oldest predicted token.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RANDOM_ITEMS   = 320;
    localparam int HOLD_CYCLES    = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int REPORT_MAX     = 10;

    localparam logic [sltok_pkg::FIELD_LEN_BITS-1:0] LEN_ONE = sltok_pkg::FIELD_LEN_BITS'(1);

    typedef struct packed {
        logic [sltok_pkg::CHAR_BITS-1:0] ch;
        logic                            eoc;
    } t_src_byte;

    logic i_clk;
    logic i_rst_n;

    sltok_in_if  in_if ();
    sltok_out_if out_if ();

    stack_language_token_scanner dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_src_byte          source_bytes[$];
    sltok_pkg::t_result tokens_due[$];
    sltok_pkg::t_result step_tokens[$];

    // scanner model state
    sltok_pkg::t_run_class                 run_kind = sltok_pkg::RUN_NONE;
    logic [sltok_pkg::FIELD_LINE_BITS-1:0] run_line = '0;
    logic [sltok_pkg::FIELD_COL_BITS-1:0]  run_col  = '0;
    logic [sltok_pkg::FIELD_LEN_BITS-1:0]  run_len  = '0;
    logic [sltok_pkg::LINE_BITS_DEF-1:0]   line_cnt = sltok_pkg::LINE_BITS_DEF'(1);
    logic [sltok_pkg::COLUMN_BITS_DEF-1:0] col_cnt  = sltok_pkg::COLUMN_BITS_DEF'(1);
    logic                                  err_seen = 1'b0;

    int                 total_bytes;
    int                 rand_base;
    int                 sent_count     = 0;
    int                 mismatch_count = 0;
    int                 idle_cycles    = 0;
    int                 hold_left      = 0;
    logic               hold_done      = 1'b0;
    t_src_byte          next_byte;
    sltok_pkg::t_result got;
    sltok_pkg::t_result want;

    function automatic sltok_pkg::t_result make_token(
        input sltok_pkg::t_kind                      kind,
        input logic [sltok_pkg::FIELD_LINE_BITS-1:0] line,
        input logic [sltok_pkg::FIELD_COL_BITS-1:0]  col,
        input logic [sltok_pkg::FIELD_LEN_BITS-1:0]  len,
        input logic [sltok_pkg::CHAR_BITS-1:0]       bad,
        input logic                                  err
    );
        sltok_pkg::t_result r;
        r.kind         = kind;
        r.start_line   = line;
        r.start_column = col;
        r.token_length = len;
        r.bad_byte     = bad;
        r.had_error    = err;
        r.last_result  = 1'b0;
        return r;
    endfunction

    task automatic add_token(input sltok_pkg::t_result r);
        step_tokens = {step_tokens, r};
    endtask

    task automatic show_token(input string tag, input sltok_pkg::t_result r);
        $display("  %s kind %0d line %0d col %0d len %0d bad %02h err %b last %b",
                 tag, r.kind, r.start_line, r.start_column, r.token_length,
                 r.bad_byte, r.had_error, r.last_result);
    endtask

    task automatic restart_source();
        run_kind = sltok_pkg::RUN_NONE;
        run_line = '0;
        run_col  = '0;
        run_len  = '0;
        line_cnt = sltok_pkg::LINE_BITS_DEF'(1);
        col_cnt  = sltok_pkg::COLUMN_BITS_DEF'(1);
        err_seen = 1'b0;
    endtask

    task automatic close_run();
        if (run_kind == sltok_pkg::RUN_LETTER) begin
            add_token(make_token(sltok_pkg::KIND_NAME, run_line, run_col, run_len,
                                 '0, 1'b0));
        end else if (run_kind == sltok_pkg::RUN_DIGIT) begin
            add_token(make_token(sltok_pkg::KIND_NUMBER, run_line, run_col, run_len,
                                 '0, 1'b0));
        end
        run_kind = sltok_pkg::RUN_NONE;
        run_line = '0;
        run_col  = '0;
        run_len  = '0;
    endtask

    task automatic scan_byte(input logic [sltok_pkg::CHAR_BITS-1:0] c, input logic eoc);
        sltok_pkg::t_run_class cls;
        sltok_pkg::t_kind      op;
        logic                  op_hit;
        cls    = sltok_pkg::RUN_NONE;
        op     = sltok_pkg::KIND_MOVE;
        op_hit = 1'b1;
        step_tokens.delete();
        if ((c >= sltok_pkg::CH_LOW_A && c <= sltok_pkg::CH_LOW_Z) ||
            (c >= sltok_pkg::CH_UP_A && c <= sltok_pkg::CH_UP_Z)) begin
            cls = sltok_pkg::RUN_LETTER;
        end else if (c >= sltok_pkg::CH_ZERO && c <= sltok_pkg::CH_NINE) begin
            cls = sltok_pkg::RUN_DIGIT;
        end
        if (run_kind != cls) begin
            close_run();
        end
        if (cls != sltok_pkg::RUN_NONE) begin
            if (run_kind == sltok_pkg::RUN_NONE) begin
                run_kind = cls;
                run_line = line_cnt;
                run_col  = col_cnt;
                run_len  = LEN_ONE;
            end else if (run_len != sltok_pkg::FIELD_LEN_MAX) begin
                run_len = run_len + LEN_ONE;
            end
            if (eoc) begin
                close_run();
            end
        end else begin
            case (c)
                sltok_pkg::CH_GT:     op = sltok_pkg::KIND_MOVE;
                sltok_pkg::CH_PLUS:   op = sltok_pkg::KIND_COPY;
                sltok_pkg::CH_LBRACK: op = sltok_pkg::KIND_ZERO_OPEN;
                sltok_pkg::CH_RBRACK: op = sltok_pkg::KIND_ZERO_CLOSE;
                sltok_pkg::CH_LBRACE: op = sltok_pkg::KIND_EMPTY_OPEN;
                sltok_pkg::CH_RBRACE: op = sltok_pkg::KIND_EMPTY_CLOSE;
                default:              op_hit = 1'b0;
            endcase
            if (op_hit) begin
                add_token(make_token(op, line_cnt, col_cnt, LEN_ONE, '0, 1'b0));
            end else if (c == sltok_pkg::CH_NEWLINE) begin
                if (line_cnt != '1) begin
                    line_cnt = line_cnt + sltok_pkg::LINE_BITS_DEF'(1);
                end
                col_cnt = '0;
            end else if (c != sltok_pkg::CH_SPACE && c != sltok_pkg::CH_TAB) begin
                add_token(make_token(sltok_pkg::KIND_BAD_CHAR, line_cnt, col_cnt, LEN_ONE,
                                     c, 1'b0));
                err_seen = 1'b1;
            end
        end
        if (col_cnt != '1) begin
            col_cnt = col_cnt + sltok_pkg::COLUMN_BITS_DEF'(1);
        end
        if (eoc) begin
            add_token(make_token(sltok_pkg::KIND_END, '0, '0, '0, '0, err_seen));
            restart_source();
        end
        if (step_tokens.size() != 0) begin
            step_tokens[step_tokens.size() - 1].last_result = 1'b1;
        end
        tokens_due = {tokens_due, step_tokens};
    endtask

    task automatic queue_byte(input logic [sltok_pkg::CHAR_BITS-1:0] c, input logic eoc);
        t_src_byte b;
        b.ch  = c;
        b.eoc = eoc;
        source_bytes = {source_bytes, b};
    endtask

    function automatic logic [sltok_pkg::CHAR_BITS-1:0] random_letter();
        if ($urandom_range(0, 1) == 0) begin
            return sltok_pkg::CH_LOW_A + sltok_pkg::CHAR_BITS'($urandom_range(0, 25));
        end else begin
            return sltok_pkg::CH_UP_A + sltok_pkg::CHAR_BITS'($urandom_range(0, 25));
        end
    endfunction

    function automatic logic [sltok_pkg::CHAR_BITS-1:0] random_digit();
        return sltok_pkg::CH_ZERO + sltok_pkg::CHAR_BITS'($urandom_range(0, 9));
    endfunction

    function automatic logic [sltok_pkg::CHAR_BITS-1:0] random_operator();
        case ($urandom_range(0, 5))
            0:       return sltok_pkg::CH_GT;
            1:       return sltok_pkg::CH_PLUS;
            2:       return sltok_pkg::CH_LBRACK;
            3:       return sltok_pkg::CH_RBRACK;
            4:       return sltok_pkg::CH_LBRACE;
            default: return sltok_pkg::CH_RBRACE;
        endcase
    endfunction

    // one token of a well-formed source, or noise now and then
    task automatic queue_token(input logic eoc);
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                queue_byte(random_letter(), eoc && i == len - 1);
            end
        end else if (pick < 40) begin
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++) begin
                queue_byte(random_digit(), eoc && i == len - 1);
            end
        end else if (pick < 65) begin
            queue_byte(random_operator(), eoc);
        end else if (pick < 80) begin
            queue_byte(($urandom_range(0, 1) == 0) ? sltok_pkg::CH_SPACE : sltok_pkg::CH_TAB,
                       eoc);
        end else if (pick < 88) begin
            queue_byte(sltok_pkg::CH_NEWLINE, eoc);
        end else begin
            queue_byte(sltok_pkg::CHAR_BITS'($urandom_range(0, 255)), eoc);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        int tokens;
        i_rst_n = 1'b0;

        // runs, operators, whitespace, bad bytes at both extremes, end with error
        queue_byte(sltok_pkg::CH_UP_A, 1'b0);
        queue_byte(sltok_pkg::CH_LOW_Z, 1'b0);
        queue_byte(sltok_pkg::CH_ZERO, 1'b0);
        queue_byte(sltok_pkg::CH_NINE, 1'b0);
        queue_byte(sltok_pkg::CH_GT, 1'b0);
        queue_byte(sltok_pkg::CH_PLUS, 1'b0);
        queue_byte(sltok_pkg::CH_LBRACK, 1'b0);
        queue_byte(sltok_pkg::CH_RBRACK, 1'b0);
        queue_byte(sltok_pkg::CH_LBRACE, 1'b0);
        queue_byte(sltok_pkg::CH_RBRACE, 1'b0);
        queue_byte(sltok_pkg::CH_SPACE, 1'b0);
        queue_byte(sltok_pkg::CH_TAB, 1'b0);
        queue_byte(sltok_pkg::CH_NEWLINE, 1'b0);
        queue_byte(sltok_pkg::CH_LOW_A, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(sltok_pkg::CH_UP_Z, 1'b1);
        // clean source ending inside a digit run
        queue_byte(sltok_pkg::CH_ZERO + 8'd5, 1'b0);
        queue_byte(sltok_pkg::CH_NEWLINE, 1'b0);
        queue_byte(sltok_pkg::CH_ZERO + 8'd7, 1'b1);
        // source of only a newline
        queue_byte(sltok_pkg::CH_NEWLINE, 1'b1);
        // run, operator and end from one byte
        queue_byte(sltok_pkg::CH_LOW_A + 8'd16, 1'b0);
        queue_byte(sltok_pkg::CH_RBRACE, 1'b1);
        // operator, number, bad byte, newline and an operator ending the source
        queue_byte(sltok_pkg::CH_PLUS, 1'b0);
        queue_byte(sltok_pkg::CH_ZERO + 8'd3, 1'b0);
        queue_byte(sltok_pkg::CH_ZERO + 8'd4, 1'b0);
        queue_byte(8'h25, 1'b0);
        queue_byte(sltok_pkg::CH_NEWLINE, 1'b0);
        queue_byte(sltok_pkg::CH_GT, 1'b1);

        rand_base = source_bytes.size();
        while (source_bytes.size() - rand_base < RANDOM_ITEMS) begin
            tokens = $urandom_range(3, 30);
            for (int k = 0; k < tokens; k++) begin
                queue_token(1'b0);
            end
            queue_token(1'b1);
        end
        total_bytes = source_bytes.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (idle_cycles < WATCHDOG_LIMIT &&
               (sent_count != total_bytes || tokens_due.size() != 0)) begin
            @(posedge i_clk);
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
        end else begin
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            if (mismatch_count == 0) begin
                $display("SUCCESS");
            end else begin
                $display("FAILURE");
            end
        end
        $finish;
    end

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid       <= 1'b0;
            in_if.char_byte   <= '0;
            in_if.end_of_code <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                scan_byte(in_if.char_byte, in_if.end_of_code);
                sent_count <= sent_count + 1;
            end
            if (!in_if.valid || in_if.ready) begin
                if (source_bytes.size() != 0 &&
                    ((sent_count >= rand_base + 20 && sent_count < rand_base + 120) ||
                     $urandom_range(0, 99) >= 10)) begin
                    next_byte = source_bytes.pop_front();
                    in_if.valid       <= 1'b1;
                    in_if.char_byte   <= next_byte.ch;
                    in_if.end_of_code <= next_byte.eoc;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got.kind         = sltok_pkg::t_kind'(out_if.kind);
                got.start_line   = out_if.start_line;
                got.start_column = out_if.start_column;
                got.token_length = out_if.token_length;
                got.bad_byte     = out_if.bad_byte;
                got.had_error    = out_if.had_error;
                got.last_result  = out_if.last_result;
                if (tokens_due.size() == 0) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < REPORT_MAX) begin
                        $display("unexpected token at byte %0d", sent_count);
                        show_token("got: ", got);
                    end
                end else begin
                    want = tokens_due.pop_front();
                    if (got !== want) begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < REPORT_MAX) begin
                            $display("token mismatch at byte %0d", sent_count);
                            show_token("got: ", got);
                            show_token("want:", want);
                        end
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                out_if.ready <= 1'b0;
            end else if (!hold_done && sent_count >= rand_base + 150) begin
                hold_done    <= 1'b1;
                hold_left    <= HOLD_CYCLES;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= (sent_count >= rand_base + 200 &&
                                 sent_count < rand_base + 300) ||
                                $urandom_range(0, 99) >= 10;
            end
        end
    end

    // cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

>>> sim.f
rtl/core/sltok_pkg.sv
rtl/core/sltok_if.sv
rtl/core/sltok_queue.sv
rtl/core/stack_language_token_scanner.sv
tb/sv/tb_top.sv
